// ===== design/cdma_pkg.sv =====
// Shared types and constants for the corrected-distance moving average core.
// Holds the word structs, register indexes and register reset values.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package cdma_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_OFFSET = 2'd2;

  // Reset gain is about 0.659332 in Q1.16, reset offset about 168.7536 cm in Q16.
  localparam logic [4:0]  WINDOW_LENGTH_RST     = 5'd16;
  localparam logic [16:0] CORRECTION_GAIN_RST   = 17'd43210;
  localparam logic [31:0] CORRECTION_OFFSET_RST = 32'd11059436;

  typedef struct packed {
    logic        [15:0] raw_distance_cm;
    logic signed [7:0]  sample_rssi;
  } in_word_t;

  typedef struct packed {
    logic        [15:0] corrected_distance_cm;
    logic        [15:0] avg_distance_cm;
    logic signed [7:0]  avg_rssi;
    logic        [4:0]  fill_count;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/corrected_distance_moving_average_core.sv =====
// A word is taken in idle and then passes through the multiply, correct-and-evict, insert,
// divide and emit states; the core takes no new word until it is back in idle. The divide
// state runs two restoring dividers that share the divisor (one quotient bit per cycle
// over the distance total width), and the emit state waits while an earlier result is
// stalled. Reset (rst_n low, synchronous) restores the register defaults and empties the
// window; the sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module corrected_distance_moving_average_core #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  cdma_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  wire                                out_stall,
  output cdma_pkg::out_word_t                out_word,
  input  wire                                cfg_we,
  input  wire  [cdma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [cdma_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cdma_pkg::*;

  // The window can never hold more than the 5-bit length register allows.
  localparam int unsigned LEN_MAX = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;
  localparam int unsigned CNT_W   = $clog2(LEN_MAX + 1);
  localparam int unsigned PTR_W   = $clog2(WINDOW_MAX);
  localparam int unsigned SUM_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int unsigned DT_W    = 16 + CNT_W;
  localparam int unsigned RT_W    = 8 + CNT_W;
  localparam int unsigned DIV_CW  = $clog2(DT_W + 1);

  // Sequencer: capture, multiply and read oldest, correct and evict, insert, divide, emit.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ADD  = 6'b000100,
    S_WR   = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [4:0]  window_length_r, window_length_nxt;
  logic [16:0] gain_r, gain_nxt;
  logic [31:0] offset_r, offset_nxt;

  // Window bookkeeping; the samples themselves live in the memory below.
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [DT_W-1:0]        dtotal_r, dtotal_nxt;
  logic signed [RT_W-1:0] rtotal_r, rtotal_nxt;

  // Datapath registers for the word in flight.
  in_word_t          in_r, in_nxt;
  logic [32:0]       prod_r, prod_nxt;
  logic [15:0]       corr_r, corr_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]  drem_r, drem_nxt;
  logic [DT_W-1:0]   dquo_r, dquo_nxt;
  logic [CNT_W-1:0]  rrem_r, rrem_nxt;
  logic [DT_W-1:0]   rquo_r, rquo_nxt;
  logic              rneg_r, rneg_nxt;
  logic [DIV_CW-1:0] dcnt_r, dcnt_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Sample memory: corrected distance in the upper 16 bits, RSSI in the lower 8.
  logic [23:0]      mem [WINDOW_MAX];
  logic [23:0]      rd_data_r;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [23:0]      mem_wdata;

  // Combinational helpers.
  logic [CNT_W-1:0]       len_eff;
  logic [6:0]             wl_ext;
  logic [33:0]            acc;
  logic                   evict;
  logic [PTR_W:0]         ptr_inc;
  logic [SUM_W-1:0]       slot_sum;
  logic [PTR_W-1:0]       slot;
  logic [RT_W-1:0]        rmag;
  logic [CNT_W:0]         dtrial, rtrial;
  logic                   dbit, rbit;
  logic [7:0]             rq8;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[ptr_r];
  end

  always_comb begin
    // Effective window length: zero acts as one, anything above the memory depth is clamped.
    wl_ext = {2'b00, window_length_r};
    if (window_length_r == 5'd0) begin
      len_eff = CNT_W'(1);
    end else if (wl_ext > 7'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(window_length_r);
    end

    acc     = {1'b0, offset_r} + {1'b0, prod_r};
    evict   = (count_r >= len_eff) && (count_r != '0);
    ptr_inc = {1'b0, ptr_r} + (PTR_W+1)'(1);

    slot_sum = SUM_W'(ptr_r) + SUM_W'(count_r);
    if (slot_sum >= SUM_W'(WINDOW_MAX)) begin
      slot = PTR_W'(slot_sum - SUM_W'(WINDOW_MAX));
    end else begin
      slot = PTR_W'(slot_sum);
    end

    // One restoring step for each divider; both share the divisor.
    dtrial = {drem_r, dquo_r[DT_W-1]};
    rtrial = {rrem_r, rquo_r[DT_W-1]};
    dbit   = (dtrial >= {1'b0, div_r});
    rbit   = (rtrial >= {1'b0, div_r});
    rq8    = rquo_r[7:0];

    state_nxt         = state_r;
    window_length_nxt = window_length_r;
    gain_nxt          = gain_r;
    offset_nxt        = offset_r;
    ptr_nxt           = ptr_r;
    count_nxt         = count_r;
    dtotal_nxt        = dtotal_r;
    rtotal_nxt        = rtotal_r;
    in_nxt            = in_r;
    prod_nxt          = prod_r;
    corr_nxt          = corr_r;
    div_nxt           = div_r;
    drem_nxt          = drem_r;
    dquo_nxt          = dquo_r;
    rrem_nxt          = rrem_r;
    rquo_nxt          = rquo_r;
    rneg_nxt          = rneg_r;
    dcnt_nxt          = dcnt_r;
    out_nxt           = out_r;
    out_valid_nxt     = out_valid_r;
    rmag              = '0;
    mem_we            = 1'b0;
    mem_waddr         = slot;
    mem_wdata         = {corr_r, in_r.sample_rssi};

    // A word that is taken frees the output register.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_word;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // The oldest sample is read from the memory in this same cycle.
        prod_nxt  = gain_r * in_r.raw_distance_cm;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (acc[33:32] != 2'b00) begin
          corr_nxt = 16'hFFFF;
        end else begin
          corr_nxt = acc[31:16];
        end
        if (evict) begin
          dtotal_nxt = dtotal_r - DT_W'(rd_data_r[23:8]);
          rtotal_nxt = rtotal_r - {{(RT_W-8){rd_data_r[7]}}, rd_data_r[7:0]};
          ptr_nxt    = (ptr_inc == (PTR_W+1)'(WINDOW_MAX)) ? '0 : ptr_inc[PTR_W-1:0];
          count_nxt  = count_r - CNT_W'(1);
        end
        state_nxt = S_WR;
      end
      S_WR: begin
        mem_we     = 1'b1;
        count_nxt  = count_r + CNT_W'(1);
        dtotal_nxt = dtotal_r + DT_W'(corr_r);
        rtotal_nxt = rtotal_r + {{(RT_W-8){in_r.sample_rssi[7]}}, in_r.sample_rssi};
        // Load both dividers with the updated totals; the RSSI side works on magnitude.
        rmag       = rtotal_nxt[RT_W-1] ? RT_W'(-rtotal_nxt) : RT_W'(rtotal_nxt);
        rneg_nxt   = rtotal_nxt[RT_W-1];
        div_nxt    = count_nxt;
        dquo_nxt   = dtotal_nxt;
        rquo_nxt   = DT_W'(rmag);
        drem_nxt   = '0;
        rrem_nxt   = '0;
        dcnt_nxt   = DIV_CW'(DT_W);
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        drem_nxt = dbit ? CNT_W'(dtrial - {1'b0, div_r}) : dtrial[CNT_W-1:0];
        rrem_nxt = rbit ? CNT_W'(rtrial - {1'b0, div_r}) : rtrial[CNT_W-1:0];
        dquo_nxt = {dquo_r[DT_W-2:0], dbit};
        rquo_nxt = {rquo_r[DT_W-2:0], rbit};
        dcnt_nxt = dcnt_r - DIV_CW'(1);
        if (dcnt_r == DIV_CW'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Wait here only while a previous result still sits unread.
        if (!out_valid_r || !out_stall) begin
          out_nxt.corrected_distance_cm = corr_r;
          out_nxt.avg_distance_cm       = dquo_r[15:0];
          out_nxt.avg_rssi              = rneg_r ? -rq8 : rq8;
          out_nxt.fill_count            = 5'(count_r);
          out_valid_nxt                 = 1'b1;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes must come only in idle (not enforced); unknown indexes are ignored.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: begin
          window_length_nxt = cfg_data[4:0];
          ptr_nxt           = '0;
          count_nxt         = '0;
          dtotal_nxt        = '0;
          rtotal_nxt        = '0;
        end
        REG_CORRECTION_GAIN: begin
          gain_nxt = cfg_data[16:0];
        end
        REG_CORRECTION_OFFSET: begin
          offset_nxt = cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      window_length_r <= WINDOW_LENGTH_RST;
      gain_r          <= CORRECTION_GAIN_RST;
      offset_r        <= CORRECTION_OFFSET_RST;
      ptr_r           <= '0;
      count_r         <= '0;
      dtotal_r        <= '0;
      rtotal_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      window_length_r <= window_length_nxt;
      gain_r          <= gain_nxt;
      offset_r        <= offset_nxt;
      ptr_r           <= ptr_nxt;
      count_r         <= count_nxt;
      dtotal_r        <= dtotal_nxt;
      rtotal_r        <= rtotal_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    prod_r <= prod_nxt;
    corr_r <= corr_nxt;
    div_r  <= div_nxt;
    drem_r <= drem_nxt;
    dquo_r <= dquo_nxt;
    rrem_r <= rrem_nxt;
    rquo_r <= rquo_nxt;
    rneg_r <= rneg_nxt;
    dcnt_r <= dcnt_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== design/cdma_checker.sv =====
// Port-level checker for the corrected-distance moving average core.
// Depends on cdma_pkg; bound to the core at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module cdma_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input cdma_pkg::out_word_t out_word
);
  import cdma_pkg::*;

  // The core works on one word at a time, so it stalls right after taking one.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word was still in flight");

  // Every result averages at least one sample.
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.fill_count != 5'd0)
    else $error("result with an empty window");

  // With one sample in the window its average is the sample itself.
  a_single_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.fill_count == 5'd1 |->
      out_word.avg_distance_cm == out_word.corrected_distance_cm)
    else $error("single-sample average differs from the corrected distance");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word was dropped or changed");

endmodule

bind corrected_distance_moving_average_core cdma_checker u_cdma_checker (.*);

`default_nettype wire
